>>> hw/rtl/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

	localparam int MANT_W    = 96;
	localparam int SCALE_W   = 5;
	localparam int IN_W      = 208;
	localparam int OUT_W     = 200;

	// long division by ten, one chunk of the dividend per cycle
	localparam int CHUNK_W   = 24;
	localparam int DIV_STEPS = MANT_W / CHUNK_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int CUR_W     = CHUNK_W + 4;
	// ceil(2^31 / 10): exact quotient for every partial dividend below 2^30
	localparam int RECIP_SH  = 31;
	localparam logic [CUR_W-1:0] RECIP_TEN = CUR_W'(214748365);

	typedef enum logic {
		OPND_A,
		OPND_B
	} opnd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIP_SEL,
		ST_STRIP_DIV,
		ST_STRIP_END,
		ST_ALIGN_CHK,
		ST_ALIGN_DIV,
		ST_ALIGN_RND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  load;
		logic  div_load;
		logic  div_step;
		logic  strip_commit;
		logic  mul_commit;
		logic  round_commit;
		logic  publish;
		opnd_t sel;
	} cmd_t;

	typedef struct packed {
		logic a_scale_zero;
		logic b_scale_zero;
		logic rem_zero;
		logic scales_eq;
		logic a_lower;
		logic mul_ovf;
		logic out_busy;
	} sts_t;

endpackage

>>> hw/rtl/dsa_ctrl.sv
`timescale 1ns / 1ps

module dsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_ready,
	input  dsa_pkg::sts_t sts,
	output logic          in_ready,
	output dsa_pkg::cmd_t cmd
);

	dsa_pkg::state_t                state_q, state_nx;
	dsa_pkg::opnd_t                 sel_q, sel_nx;
	logic [dsa_pkg::CNT_W-1:0]      cnt_q;
	logic                           cnt_last;
	logic                           sel_scale_zero;
	dsa_pkg::opnd_t                 lower, higher;

	assign cnt_last       = (cnt_q == dsa_pkg::CNT_W'(dsa_pkg::DIV_STEPS - 1));
	assign sel_scale_zero = (sel_q == dsa_pkg::OPND_A) ? sts.a_scale_zero : sts.b_scale_zero;
	assign lower          = sts.a_lower ? dsa_pkg::OPND_A : dsa_pkg::OPND_B;
	assign higher         = sts.a_lower ? dsa_pkg::OPND_B : dsa_pkg::OPND_A;
	assign in_ready       = (state_q == dsa_pkg::ST_IDLE);

	always_comb begin
		state_nx = state_q;
		sel_nx   = sel_q;
		case (state_q)
			dsa_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_nx = dsa_pkg::ST_STRIP_SEL;
					sel_nx   = dsa_pkg::OPND_A;
				end
			end
			dsa_pkg::ST_STRIP_SEL: begin
				if (!sel_scale_zero) begin
					state_nx = dsa_pkg::ST_STRIP_DIV;
				end else if (sel_q == dsa_pkg::OPND_A) begin
					sel_nx = dsa_pkg::OPND_B;
				end else begin
					state_nx = dsa_pkg::ST_ALIGN_CHK;
				end
			end
			dsa_pkg::ST_STRIP_DIV: begin
				if (cnt_last)
					state_nx = dsa_pkg::ST_STRIP_END;
			end
			dsa_pkg::ST_STRIP_END: begin
				if (sts.rem_zero) begin
					state_nx = dsa_pkg::ST_STRIP_SEL;
				end else if (sel_q == dsa_pkg::OPND_A) begin
					state_nx = dsa_pkg::ST_STRIP_SEL;
					sel_nx   = dsa_pkg::OPND_B;
				end else begin
					state_nx = dsa_pkg::ST_ALIGN_CHK;
				end
			end
			dsa_pkg::ST_ALIGN_CHK: begin
				if (sts.scales_eq) begin
					state_nx = dsa_pkg::ST_DONE;
				end else if (sts.mul_ovf) begin
					state_nx = dsa_pkg::ST_ALIGN_DIV;
					sel_nx   = higher;
				end
			end
			dsa_pkg::ST_ALIGN_DIV: begin
				if (cnt_last)
					state_nx = dsa_pkg::ST_ALIGN_RND;
			end
			dsa_pkg::ST_ALIGN_RND: begin
				state_nx = dsa_pkg::ST_ALIGN_CHK;
			end
			dsa_pkg::ST_DONE: begin
				if (!sts.out_busy || out_ready)
					state_nx = dsa_pkg::ST_IDLE;
			end
			default: begin
				state_nx = dsa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.sel = sel_q;
		case (state_q)
			dsa_pkg::ST_IDLE: begin
				cmd.load = in_fire;
			end
			dsa_pkg::ST_STRIP_SEL: begin
				cmd.div_load = !sel_scale_zero;
			end
			dsa_pkg::ST_STRIP_DIV: begin
				cmd.div_step = 1'b1;
			end
			dsa_pkg::ST_STRIP_END: begin
				cmd.strip_commit = sts.rem_zero;
			end
			dsa_pkg::ST_ALIGN_CHK: begin
				if (!sts.scales_eq) begin
					if (sts.mul_ovf) begin
						cmd.div_load = 1'b1;
						cmd.sel      = higher;
					end else begin
						cmd.mul_commit = 1'b1;
						cmd.sel        = lower;
					end
				end
			end
			dsa_pkg::ST_ALIGN_DIV: begin
				cmd.div_step = 1'b1;
			end
			dsa_pkg::ST_ALIGN_RND: begin
				cmd.round_commit = 1'b1;
			end
			dsa_pkg::ST_DONE: begin
				cmd.publish = !sts.out_busy || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsa_pkg::ST_IDLE;
			sel_q   <= dsa_pkg::OPND_A;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			sel_q   <= sel_nx;
			if (cmd.div_load)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

>>> hw/rtl/dsa_dp.sv
`timescale 1ns / 1ps

module dsa_dp #(
	parameter int MAX_SCALE = 28
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dsa_pkg::cmd_t              cmd,
	input  logic [dsa_pkg::IN_W-1:0]   in_data,
	input  logic                       out_ready,
	output dsa_pkg::sts_t              sts,
	output logic                       out_valid,
	output logic [dsa_pkg::OUT_W-1:0]  out_data
);

	localparam int MW = dsa_pkg::MANT_W;
	localparam int SW = dsa_pkg::SCALE_W;
	localparam int CW = dsa_pkg::CUR_W;
	localparam int KW = dsa_pkg::CHUNK_W;

	logic [MW-1:0]     a_q, b_q;
	logic [SW-1:0]     sa_q, sb_q;
	logic              na_q, nb_q;
	logic [MW-1:0]     w_q;
	logic [3:0]        rem_q;
	logic              out_valid_q;
	logic [dsa_pkg::OUT_W-1:0] out_q;

	logic [SW-1:0]     sa_in, sb_in, sa_sat, sb_sat;
	logic [MW-1:0]     sel_mant, lo_mant;
	logic [MW+3:0]     lo_x10;
	logic [CW-1:0]     cur, q_x10, rem_full;
	logic [2*CW-1:0]   prod;
	logic [KW-1:0]     q_chunk;
	logic              round_up;
	logic [MW-1:0]     rounded;

	assign sa_in  = in_data[100:96];
	assign sb_in  = in_data[202:198];
	assign sa_sat = (sa_in > SW'(MAX_SCALE)) ? SW'(MAX_SCALE) : sa_in;
	assign sb_sat = (sb_in > SW'(MAX_SCALE)) ? SW'(MAX_SCALE) : sb_in;

	assign sel_mant = (cmd.sel == dsa_pkg::OPND_A) ? a_q : b_q;
	assign lo_mant  = (sa_q < sb_q) ? a_q : b_q;
	// x10 as x8 + x2
	assign lo_x10   = {1'b0, lo_mant, 3'b000} + {3'b000, lo_mant, 1'b0};

	// one long-division step by ten on the top chunk, reciprocal multiply
	assign cur      = {rem_q, w_q[MW-1 -: KW]};
	assign prod     = cur * dsa_pkg::RECIP_TEN;
	assign q_chunk  = prod[dsa_pkg::RECIP_SH +: KW];
	assign q_x10    = {1'b0, q_chunk, 3'b000} + {3'b000, q_chunk, 1'b0};
	assign rem_full = cur - q_x10;

	assign round_up = (rem_q > 4'd5) || ((rem_q == 4'd5) && w_q[0]);
	assign rounded  = w_q + MW'(round_up);

	assign sts.a_scale_zero = (sa_q == '0);
	assign sts.b_scale_zero = (sb_q == '0);
	assign sts.rem_zero     = (rem_q == '0);
	assign sts.scales_eq    = (sa_q == sb_q);
	assign sts.a_lower      = (sa_q < sb_q);
	assign sts.mul_ovf      = (lo_x10[MW+3:MW] != '0);
	assign sts.out_busy     = out_valid_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= in_data[95:0];
			sa_q <= sa_sat;
			na_q <= in_data[101];
			b_q  <= in_data[197:102];
			sb_q <= sb_sat;
			nb_q <= in_data[203];
		end else if (cmd.strip_commit || cmd.round_commit) begin
			if (cmd.sel == dsa_pkg::OPND_A) begin
				a_q  <= cmd.round_commit ? rounded : w_q;
				sa_q <= sa_q - 1'b1;
			end else begin
				b_q  <= cmd.round_commit ? rounded : w_q;
				sb_q <= sb_q - 1'b1;
			end
		end else if (cmd.mul_commit) begin
			if (cmd.sel == dsa_pkg::OPND_A) begin
				a_q  <= lo_x10[MW-1:0];
				sa_q <= sa_q + 1'b1;
			end else begin
				b_q  <= lo_x10[MW-1:0];
				sb_q <= sb_q + 1'b1;
			end
		end

		// dividend shifts up a chunk per step; quotient chunks enter at the bottom
		if (cmd.div_load) begin
			w_q   <= sel_mant;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			w_q   <= {w_q[MW-KW-1:0], q_chunk};
			rem_q <= rem_full[3:0];
		end

		if (cmd.publish)
			out_q <= {1'b0, nb_q, na_q, sa_q, b_q, a_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/decimal_scale_alignment_core.sv
`timescale 1ns / 1ps
// Work runs as trailing-zero strip attempts on each operand (an operand ends on one failed
// attempt unless its scale reaches 0), then multiply-by-ten and divide-by-ten steps until the
// scales match. One item at a time, the next accepted the cycle after a result is registered;
// the shared divide-by-ten unit works on one 24-bit chunk a cycle, four chunks per divide.
// The result register lets the next item enter while a result waits. Reset clears control only.
module decimal_scale_alignment_core #(
	parameter int MAX_SCALE = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	// first_mant_low, first_mant_high, first_scale, first_negative,
	// second_mant_low, second_mant_high, second_scale, second_negative, zero pad
	input  logic [207:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_out_low, first_out_high, second_out_low, second_out_high,
	// common_scale, first_out_negative, second_out_negative, zero pad
	output logic [199:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready
);

	dsa_pkg::cmd_t cmd;
	dsa_pkg::sts_t sts;
	logic          in_fire;

	assign in_fire = s_tvalid && s_tready;

	dsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_ready (m_tready),
		.sts       (sts),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	dsa_dp #(
		.MAX_SCALE (MAX_SCALE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule
